// ===== rtl/gcf_pkg.sv =====
package gcf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int CFG_W          = 12;
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 12;
    localparam int ROW_W          = 12;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } gcf_reg_idx_t;

    // which results one pixel produces
    typedef struct packed {
        logic grad;
        logic pass;
    } gcf_sel_t;

endpackage

// ===== rtl/gcf_line_buf.sv =====
module gcf_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // same-address collision returns the new data
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gcf_out_buf.sv =====
module gcf_out_buf #(
    parameter int COL_W = 10,
    parameter int VAL_W = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  gcf_pkg::gcf_sel_t        sel,
    input  logic [gcf_pkg::ROW_W-1:0] row,
    input  logic [COL_W-1:0]         col,
    input  logic [VAL_W-1:0]         grad_value,
    input  logic [VAL_W-1:0]         pass_value,
    input  logic                     pass_end,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [gcf_pkg::ROW_W-1:0] out_row,
    output logic [COL_W-1:0]         out_col,
    output logic [VAL_W-1:0]         value,
    output logic                     frame_end
);

    import gcf_pkg::*;

    logic             grad_v_reg, grad_v_next;
    logic             pass_v_reg, pass_v_next;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [VAL_W-1:0] grad_value_reg;
    logic [VAL_W-1:0] pass_value_reg;
    logic             pass_end_reg;
    logic             out_accept;

    assign out_valid  = grad_v_reg || pass_v_reg;
    assign out_accept = out_valid && !out_stall;
    // empty now, or the last pending result leaves this cycle
    assign free       = !out_valid || (out_accept && !(grad_v_reg && pass_v_reg));

    always_comb
    begin
        grad_v_next = grad_v_reg;
        pass_v_next = pass_v_reg;
        if (load)
        begin
            grad_v_next = sel.grad;
            pass_v_next = sel.pass;
        end
        else if (out_accept)
        begin
            if (grad_v_reg)
            begin
                grad_v_next = 1'b0;
            end
            else
            begin
                pass_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grad_v_reg <= 1'b0;
            pass_v_reg <= 1'b0;
        end
        else
        begin
            grad_v_reg <= grad_v_next;
            pass_v_reg <= pass_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg        <= row;
            col_reg        <= col;
            grad_value_reg <= grad_value;
            pass_value_reg <= pass_value;
            pass_end_reg   <= pass_end;
        end
    end

    // gradient result belongs to the row above the incoming pixel
    assign out_row   = grad_v_reg ? (row_reg - 1'b1) : row_reg;
    assign out_col   = col_reg;
    assign value     = grad_v_reg ? grad_value_reg : pass_value_reg;
    assign frame_end = !grad_v_reg && pass_end_reg;

    a_grad_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        grad_v_reg |-> (row_reg != '0))
        else $error("gradient result pending for row zero");

endmodule

// ===== rtl/gradient_contour_filter.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------
// cfg      | cfg_wr_en            | cfg_index, cfg_data
// in       | in_valid / in_stall  | pixel
// out      | out_valid / out_stall| out_row, out_col, value, frame_end
//
// One pixel per clock while in_stall is low; a last-row pixel below the
// first row carries two results, which the output side sends in turn,
// gradient first. Each result passes through the input stage, then the result buffer.
// A config write stalls the input while the line buffer read is reloaded.
// Reset clears counters and loads 640 x 480; the line buffer is not cleared.
// out_stall backs up through the result buffer and input stage to in_stall.
module gradient_contour_filter #(
    parameter int MAX_WIDTH  = gcf_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = gcf_pkg::PIXEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  gcf_pkg::gcf_reg_idx_t        cfg_index,
    input  logic [gcf_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [PIXEL_BITS-1:0]        pixel,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [gcf_pkg::ROW_W-1:0]    out_row,
    output logic [$clog2(MAX_WIDTH)-1:0] out_col,
    output logic [PIXEL_BITS:0]          value,
    output logic                         frame_end
);

    import gcf_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int VAL_W = PIXEL_BITS + 1;
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH - 1);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    refetch_reg;

    logic [COL_W-1:0]  col_count_reg, col_count_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;

    logic [COL_W-1:0]  last_idx;
    logic [ROW_W-1:0]  last_row_idx;
    logic [COL_W-1:0]  col_cur;
    logic              is_last_col;
    logic              is_last_row;
    logic              has_up;
    logic              in_accept;

    logic              line_rd_en;
    logic [COL_W-1:0]  line_rd_addr;
    logic [PIXEL_BITS-1:0] line_rd_data;

    logic                  s1_valid_reg, s1_valid_next;
    gcf_sel_t              s1_sel_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [PIXEL_BITS-1:0] s1_up_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic                  s1_last_col_reg;

    logic                  s2_free;
    logic                  s2_load;
    logic [PIXEL_BITS-1:0] diff_down;
    logic [PIXEL_BITS-1:0] diff_right;
    logic [VAL_W-1:0]      grad_value;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            refetch_reg <= 1'b0;
        end
        else
        begin
            refetch_reg <= cfg_wr_en;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                endcase
            end
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            last_idx = COL_MAX;
        end
        else
        begin
            last_idx = COL_W'(width_reg - 1'b1);
        end
        last_row_idx = (height_reg == '0) ? '0 : (height_reg - 1'b1);
    end

    assign col_cur     = (col_count_reg > last_idx) ? last_idx : col_count_reg;
    assign is_last_col = (col_cur == last_idx);
    assign is_last_row = (row_count_reg >= last_row_idx);
    assign has_up      = (row_count_reg != '0);

    assign in_stall  = refetch_reg || (s1_valid_reg && !s2_free);
    assign in_accept = in_valid && !in_stall;

    // Read runs one column ahead: each request fetches the above-right pixel,
    // which is also the above pixel of the next request. After a config
    // write the current column is fetched again.
    assign line_rd_en = refetch_reg || in_accept;
    always_comb
    begin
        if (refetch_reg)
        begin
            line_rd_addr = col_cur;
        end
        else if (is_last_col)
        begin
            line_rd_addr = '0;
        end
        else
        begin
            line_rd_addr = col_cur + 1'b1;
        end
    end

    gcf_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (col_cur),
        .wr_data (pixel),
        .rd_en   (line_rd_en),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd_data)
    );

    // raster counters
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_accept)
        begin
            if (is_last_col)
            begin
                col_count_next = '0;
                row_count_next = is_last_row ? '0 : (row_count_reg + 1'b1);
            end
            else
            begin
                col_count_next = col_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // input stage
    assign s2_load = s1_valid_reg && s2_free;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = has_up || is_last_row;
        end
        else if (s2_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sel_reg.grad <= has_up;
            s1_sel_reg.pass <= is_last_row;
            s1_px_reg       <= pixel;
            s1_up_reg       <= line_rd_data;
            s1_row_reg      <= row_count_reg;
            s1_col_reg      <= col_cur;
            s1_last_col_reg <= is_last_col;
        end
    end

    // line_rd_data now holds the above-right pixel of the staged request
    assign diff_down  = (s1_px_reg >= s1_up_reg) ? (s1_px_reg - s1_up_reg)
                                                 : (s1_up_reg - s1_px_reg);
    assign diff_right = (line_rd_data >= s1_up_reg) ? (line_rd_data - s1_up_reg)
                                                    : (s1_up_reg - line_rd_data);
    assign grad_value = s1_last_col_reg ? VAL_W'(s1_up_reg)
                                        : (VAL_W'(diff_down) + VAL_W'(diff_right));

    gcf_out_buf #(
        .COL_W (COL_W),
        .VAL_W (VAL_W)
    ) u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s2_load),
        .sel        (s1_sel_reg),
        .row        (s1_row_reg),
        .col        (s1_col_reg),
        .grad_value (grad_value),
        .pass_value (VAL_W'(s1_px_reg)),
        .pass_end   (s1_last_col_reg),
        .free       (s2_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .value      (value),
        .frame_end  (frame_end)
    );

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_last_col && is_last_row)
            |=> (row_count_reg == '0 && col_count_reg == '0))
        else $error("raster counters did not wrap at frame end");

    a_stage_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_sel_reg.grad || s1_sel_reg.pass))
        else $error("input stage holds a request with no results");

    a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !in_accept)
        else $error("request taken during line buffer reload");

endmodule

// ===== test/tb_gradient_contour_filter.sv =====
`timescale 1ns / 100ps

module tb_gradient_contour_filter;
    import gcf_pkg::*;

    localparam int LINE_DEPTH      = MAX_WIDTH_DEF;
    localparam int COL_W           = $clog2(MAX_WIDTH_DEF);
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PIXELS   = 560;
    localparam int WIDE_PIXELS     = 48;
    localparam int TALL_MIN_PIXELS = 40;
    localparam int HOLD_PIXELS     = 8;
    localparam int MAX_REPORTS     = 20;
    localparam int DIR_ROWS        = 25;
    localparam int HOLD_CYCLES     = 300;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [8:0]       value;
        logic             frame_end;
    } contour_px_t;

    typedef enum logic {ROW_CFG, ROW_PIX} stim_kind_t;

    // one line of directed stimulus; typed rows carry their own results
    typedef struct packed {
        stim_kind_t       kind;
        gcf_reg_idx_t     idx;
        logic [CFG_W-1:0] data;
        logic [7:0]       px;
        logic             typed;
        logic [1:0]       n_res;
        contour_px_t      res0;
        contour_px_t      res1;
    } stim_row_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY, STALL_HOLD} stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    gcf_reg_idx_t       cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         pixel;
    logic               out_valid;
    logic               out_stall;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [8:0]         value;
    logic               frame_end;

    // predictor state
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
    logic [7:0]              line_mem [LINE_DEPTH];
    bit                      line_written [LINE_DEPTH];
    logic [ROW_W-1:0]        row_cnt = '0;
    logic [COL_W-1:0]        col_cnt = '0;
    contour_px_t             pending [$];

    stim_row_t cur_row;
    int        burst_left = 0;
    bit        streaming  = 1'b0;
    bit        hold_off_req  = 1'b0;
    bit        hold_off_done = 1'b0;
    int        err_cnt   = 0;
    int        pix_cnt   = 0;
    int        res_cnt   = 0;
    int        frame_cnt = 0;
    int        cycle_cnt = 0;

    gradient_contour_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .value     (value),
        .frame_end (frame_end)
    );

    always #5 clk = ~clk;

    function automatic int eff_width(input logic [WIDTH_REG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > LINE_DEPTH)
            return LINE_DEPTH;
        return w;
    endfunction

    function automatic int eff_height(input logic [HEIGHT_REG_W-1:0] h);
        return (h == 0) ? 1 : h;
    endfunction

    function automatic int abs_diff(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // advance the filter by one pixel; returns number of results
    function automatic int contour_step(input logic [7:0] px, output contour_px_t r0,
                                        output contour_px_t r1);
        int          w, h, c, r, up, val, n;
        bit          last_col, last_row;
        contour_px_t res [2];
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        c = (col_cnt >= w) ? w - 1 : col_cnt;
        r = row_cnt;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (r > 0) begin
            up = line_mem[c];
            if (last_col)
                val = up;
            else
                val = abs_diff(px, up) + abs_diff(line_mem[c + 1], up);
            res[n] = '{ROW_W'(r - 1), COL_W'(c), 9'(val), 1'b0};
            n++;
        end
        if (last_row) begin
            res[n] = '{ROW_W'(r), COL_W'(c), 9'(px), last_col};
            n++;
        end
        line_mem[c] = px;
        line_written[c] = 1'b1;
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : ROW_W'(r + 1);
        end
        else begin
            col_cnt = COL_W'(c + 1);
        end
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    function automatic contour_px_t px_at(input int r, input int c, input int v, input bit fe);
        return '{ROW_W'(r), COL_W'(c), 9'(v), fe};
    endfunction

    function automatic stim_row_t cfg_row(input gcf_reg_idx_t idx, input int data);
        stim_row_t sr;
        sr = '0;
        sr.kind = ROW_CFG;
        sr.idx  = idx;
        sr.data = CFG_W'(data);
        return sr;
    endfunction

    function automatic stim_row_t pix_row(input logic [7:0] px);
        stim_row_t sr;
        sr = '0;
        sr.kind = ROW_PIX;
        sr.px   = px;
        return sr;
    endfunction

    function automatic stim_row_t pix_chk(input logic [7:0] px, input int n,
                                          input contour_px_t r0, input contour_px_t r1);
        stim_row_t sr;
        sr = pix_row(px);
        sr.typed = 1'b1;
        sr.n_res = 2'(n);
        sr.res0  = r0;
        sr.res1  = r1;
        return sr;
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int rand_width();
        case ($urandom_range(0, 19))
            0: return 0;
            1, 2: return $urandom_range(13, 40);
            3: return 1;
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    function automatic int rand_height();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2, 3: return $urandom_range(7, 16);
            default: return $urandom_range(2, 6);
        endcase
    endfunction

    // a wider row must only read line entries that hold data
    function automatic bit width_fits(input int w_reg);
        int w;
        w = eff_width(WIDTH_REG_W'(w_reg));
        if (row_cnt == 0)
            return 1'b1;
        for (int k = 0; k < w; k++)
            if (!line_written[k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic field_error(input contour_px_t want, input string fname,
                               input logic [31:0] want_v, input logic [31:0] got_v);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t: pixel (%0d,%0d) %s: expected %0d, got %0d",
                     $time, want.row, want.col, fname, want_v, got_v);
    endtask

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result checking and prediction, both at the rising edge
    always @(posedge clk) begin : scoreboard
        contour_px_t got, want, p0, p1;
        int          n;
        if (rst_n) begin
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                got = '{out_row, out_col, value, frame_end};
                res_cnt++;
                if (frame_end === 1'b1)
                    frame_cnt++;
                if (pending.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got (%0d,%0d) %0d fe %0b",
                                 $time, out_row, out_col, value, frame_end);
                end
                else begin
                    want = pending.pop_front();
                    if (got.row !== want.row)
                        field_error(want, "out_row", want.row, got.row);
                    if (got.col !== want.col)
                        field_error(want, "out_col", want.col, got.col);
                    if (got.value !== want.value)
                        field_error(want, "value", want.value, got.value);
                    if (got.frame_end !== want.frame_end)
                        field_error(want, "frame_end", want.frame_end, got.frame_end);
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_REG_W-1:0];
                else
                    height_reg = cfg_data[HEIGHT_REG_W-1:0];
            end
            if (in_valid && in_stall === 1'b0) begin
                pix_cnt++;
                n = contour_step(pixel, p0, p1);
                if (cur_row.typed) begin
                    n  = cur_row.n_res;
                    p0 = cur_row.res0;
                    p1 = cur_row.res1;
                end
                if (n > 0)
                    pending.push_back(p0);
                if (n > 1)
                    pending.push_back(p1);
            end
        end
    end

    // receiver: stall pattern changes after each random span
    initial begin : stall_gen
        stall_mode_t mode;
        int          span;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            case ($urandom_range(0, 4))
                1: mode = STALL_LIGHT;
                2: mode = STALL_HALF;
                3: mode = STALL_HEAVY;
                default: mode = STALL_NONE;
            endcase
            span = $urandom_range(10, 150);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                mode = STALL_HOLD;
                span = HOLD_CYCLES;
            end
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_HOLD:  out_stall <= 1'b1;
                    default:     out_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic push_pixel(input stim_row_t sr);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_row = sr;
        in_valid <= 1'b1;
        pixel <= sr.px;
        streaming = 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        burst_left--;
    endtask

    // wait for all results, then for requests that cause none to leave the pipe
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        streaming = 1'b0;
    endtask

    task automatic write_reg(input gcf_reg_idx_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_config();
        int w, h;
        if (row_cnt == 0 && col_cnt == 0) begin
            w = rand_width();
            h = rand_height();
            if (w > 12)
                h = $urandom_range(1, 4);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        end
        else if ($urandom_range(0, 3) == 0) begin
            // change mid-frame
            w = $urandom_range(0, 12);
            if (width_fits(w))
                write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 6)));
        end
    endtask

    initial begin : stimulus
        stim_row_t dir_tab [DIR_ROWS];
        int        n_rand, n_tall, span, w, h, c;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel     = '0;
        cur_row   = '0;
        dir_tab = '{
            // single row: every pixel passes through
            cfg_row(REG_IMAGE_WIDTH, 2),
            cfg_row(REG_IMAGE_HEIGHT, 1),
            pix_chk(8'd0,   1, px_at(0, 0, 0, 1'b0),   '0),
            pix_chk(8'd255, 1, px_at(0, 1, 255, 1'b1), '0),
            // zero sizes act as 1x1
            cfg_row(REG_IMAGE_WIDTH, 0),
            cfg_row(REG_IMAGE_HEIGHT, 0),
            pix_chk(8'd255, 1, px_at(0, 0, 255, 1'b1), '0),
            pix_chk(8'd0,   1, px_at(0, 0, 0, 1'b1),   '0),
            // 2x2: top row only stored, largest gradient sum
            cfg_row(REG_IMAGE_WIDTH, 2),
            cfg_row(REG_IMAGE_HEIGHT, 2),
            pix_chk(8'd255, 0, '0, '0),
            pix_chk(8'd0,   0, '0, '0),
            pix_chk(8'd0,   2, px_at(0, 0, 510, 1'b0), px_at(1, 0, 0, 1'b0)),
            pix_chk(8'd255, 2, px_at(0, 1, 0, 1'b0),   px_at(1, 1, 255, 1'b1)),
            // 3x3 shrunk to 2 wide and 2 high mid-frame
            cfg_row(REG_IMAGE_WIDTH, 3),
            cfg_row(REG_IMAGE_HEIGHT, 3),
            pix_row(8'd17),
            pix_row(8'd200),
            pix_row(8'd99),
            pix_row(8'd5),
            cfg_row(REG_IMAGE_WIDTH, 2),
            pix_row(8'd77),
            cfg_row(REG_IMAGE_HEIGHT, 2),
            pix_row(8'd130),
            pix_row(8'd3)
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                if (streaming)
                    drain();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            else begin
                push_pixel(dir_tab[i]);
            end
        end
        drain();

        // all-ones width register: masked to 11 bits, then capped at the line size;
        // a single-row frame lets the column run well past the small sizes
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
        repeat (WIDE_PIXELS) push_pixel(pix_row(rand_pixel()));
        drain();

        // one column, tallest height; receiver holds off while the sender keeps going
        write_reg(REG_IMAGE_WIDTH, CFG_W'(1));
        write_reg(REG_IMAGE_HEIGHT, '1);
        hold_off_req = 1'b1;
        n_tall = 0;
        while (!hold_off_done || n_tall < TALL_MIN_PIXELS) begin
            push_pixel(pix_row(rand_pixel()));
            n_tall++;
        end
        repeat (HOLD_PIXELS) push_pixel(pix_row(rand_pixel()));
        drain();

        // height drops below the current row, so that row ends the frame
        write_reg(REG_IMAGE_WIDTH, CFG_W'(8));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(4));
        n_rand = 0;
        while (n_rand < RANDOM_PIXELS) begin
            if (n_rand > 0) begin
                drain();
                random_config();
            end
            w = eff_width(width_reg);
            h = eff_height(height_reg);
            c = (col_cnt >= w) ? w - 1 : col_cnt;
            // mostly run to the end of the frame, sometimes stop partway
            if ($urandom_range(0, 3) != 0)
                span = (w - c) + ((row_cnt < h - 1) ? (h - 1 - row_cnt) * w : 0);
            else
                span = $urandom_range(1, 2 * w);
            repeat (span) push_pixel(pix_row(rand_pixel()));
            n_rand += span;
        end
        drain();

        if (pending.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d expected results never arrived", $time, pending.size());
        end
        $display("checked %0d results from %0d pixels, %0d frames completed",
                 res_cnt, pix_cnt, frame_cnt);
        $display("covered small and zero sizes, all-ones width, tallest height, resizing mid-frame, long hold-off");
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gcf_pkg.sv
rtl/gcf_line_buf.sv
rtl/gcf_out_buf.sv
rtl/gradient_contour_filter.sv
test/tb_gradient_contour_filter.sv
